### rtl/swfc_pkg.sv
// package: types, constants and crc function of the sync word frame crc checker
`timescale 1ns / 1ps
`default_nettype none

package swfc_pkg;

  localparam int unsigned MaxPayload = 4096;
  localparam int unsigned LenWidth   = $clog2(MaxPayload + 1);
  localparam int unsigned SyncWidth  = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CrcWidth   = 16;
  localparam int unsigned EvWidth    = 3;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CrcWidth-1:0]  CrcInit       = 16'hFFFF;
  localparam logic [CrcWidth-1:0]  CrcPoly       = 16'h1021;
  localparam logic [SyncWidth-1:0] SyncReset     = 32'hAABBCCDD;
  localparam logic [LenWidth-1:0]  PayloadLenRst = LenWidth'(128);

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SYNC_PATTERN   = 2'd0,
    REG_PAYLOAD_LENGTH = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC_HI  = 2'd2,
    PH_CRC_LO  = 2'd3
  } frame_phase_e;

  typedef enum logic [EvWidth-1:0] {
    EV_HUNT   = 3'd0,
    EV_SYNC   = 3'd1,
    EV_DATA   = 3'd2,
    EV_CRC_HI = 3'd3,
    EV_GOOD   = 3'd4,
    EV_BAD    = 3'd5
  } event_e;

  function automatic logic [CrcWidth-1:0] crc_fold(input logic [CrcWidth-1:0] crc,
                                                  input logic [ByteWidth-1:0] b);
    logic [CrcWidth-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < ByteWidth; k++) begin
      if (c[CrcWidth-1]) begin
        c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcWidth-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/swfc_in_if.sv
// interface: received byte channel
`timescale 1ns / 1ps
`default_nettype none

interface swfc_in_if
  import swfc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/swfc_out_if.sv
// interface: frame event result channel
`timescale 1ns / 1ps
`default_nettype none

interface swfc_out_if
  import swfc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [EvWidth-1:0]   event_code;
  logic [ByteWidth-1:0] payload_out;
  logic                 last_payload;

  modport source (output valid, output event_code, output payload_out, output last_payload,
                  input ready);
  modport sink   (input valid, input event_code, input payload_out, input last_payload,
                  output ready);
endinterface

`default_nettype wire

### rtl/sync_word_frame_crc_checker_core.sv
// top level: sync word framer with streaming crc-16 frame check
//
// rx carries one received byte per request; res returns exactly one result per
// request: an event code, the payload byte (zero unless a payload event) and a
// flag on the last payload byte of a frame.
// while hunting, bytes are matched against the four sync bytes, first byte in
// bits 31..24; a mismatch restarts the hunt. then payload_length bytes (zero
// as one, over 4096 as 4096) are streamed and folded into a crc-16 (init ffff,
// poly 1021), then two crc bytes, high first, and a good or bad frame event.
// the result of an accepted request is registered and shows on res next cycle.
// throughput: one byte per cycle while res takes each result; the byte-wide
// crc fold and counter update sit between request handshake and result register.
// a stalled receiver holds the result register; rx.ready stays high while the
// result register is empty or being taken in the same cycle.
// reset clears the frame state and loads sync pattern aabbccdd and length 128.
// cfg writes (index 0 sync pattern, 1 payload length) take effect at once. the user must
// issue them only while no request is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_crc_checker_core
  import swfc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  swfc_in_if.sink                     rx,
  swfc_out_if.source                  res,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [SyncWidth-1:0]   cfg_wdata_i
);

  logic [SyncWidth-1:0] sync_pattern_q;
  logic [LenWidth-1:0]  payload_length_q;

  frame_phase_e         phase_q, phase_d;
  logic [1:0]           sync_cnt_q, sync_cnt_d;
  logic [LenWidth-1:0]  payload_cnt_q, payload_cnt_d;
  logic [CrcWidth-1:0]  crc_q, crc_d;
  logic [ByteWidth-1:0] crc_hi_q, crc_hi_d;

  logic                 out_valid_q;
  event_e               ev_q, ev_d;
  logic [ByteWidth-1:0] pout_q, pout_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic [ByteWidth-1:0] want_byte;
  logic [LenWidth-1:0]  eff_len;
  logic [LenWidth-1:0]  cnt_inc;
  logic [CrcWidth-1:0]  crc_next;

  assign rx.ready = !out_valid_q || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign want_byte = sync_pattern_q[{~sync_cnt_q, 3'b000} +: ByteWidth];
  assign crc_next  = crc_fold(crc_q, rx.rx_byte);
  assign cnt_inc   = (payload_cnt_q < LenWidth'(MaxPayload)) ? payload_cnt_q + 1'b1
                                                              : payload_cnt_q;

  always_comb begin
    eff_len = payload_length_q;
    if (payload_length_q == '0) begin
      eff_len = LenWidth'(1);
    end else if (payload_length_q > LenWidth'(MaxPayload)) begin
      eff_len = LenWidth'(MaxPayload);
    end
  end

  // next state
  always_comb begin
    phase_d       = phase_q;
    sync_cnt_d    = sync_cnt_q;
    payload_cnt_d = payload_cnt_q;
    crc_d         = crc_q;
    crc_hi_d      = crc_hi_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx.rx_byte == want_byte) begin
          if (sync_cnt_q == 2'd3) begin
            sync_cnt_d    = '0;
            payload_cnt_d = '0;
            crc_d         = CrcInit;
            phase_d       = PH_PAYLOAD;
          end else begin
            sync_cnt_d = sync_cnt_q + 2'd1;
          end
        end else begin
          sync_cnt_d = '0;
        end
      end
      PH_PAYLOAD: begin
        crc_d         = crc_next;
        payload_cnt_d = cnt_inc;
        if (cnt_inc >= eff_len) begin
          phase_d = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_d = rx.rx_byte;
        phase_d  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        phase_d       = PH_HUNT;
        sync_cnt_d    = '0;
        payload_cnt_d = '0;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // result
  always_comb begin
    ev_d   = EV_HUNT;
    pout_d = '0;
    last_d = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        ev_d = (rx.rx_byte == want_byte) ? EV_SYNC : EV_HUNT;
      end
      PH_PAYLOAD: begin
        ev_d   = EV_DATA;
        pout_d = rx.rx_byte;
        last_d = (cnt_inc >= eff_len);
      end
      PH_CRC_HI: ev_d = EV_CRC_HI;
      PH_CRC_LO: begin
        ev_d = ({crc_hi_q, rx.rx_byte} == crc_q) ? EV_GOOD : EV_BAD;
      end
      default: ev_d = EV_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pattern_q   <= SyncReset;
      payload_length_q <= PayloadLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SYNC_PATTERN:   sync_pattern_q   <= cfg_wdata_i;
        REG_PAYLOAD_LENGTH: payload_length_q <= cfg_wdata_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      sync_cnt_q    <= '0;
      payload_cnt_q <= '0;
      crc_q         <= CrcInit;
      crc_hi_q      <= '0;
    end else if (accept) begin
      phase_q       <= phase_d;
      sync_cnt_q    <= sync_cnt_d;
      payload_cnt_q <= payload_cnt_d;
      crc_q         <= crc_d;
      crc_hi_q      <= crc_hi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= ev_d;
      pout_q <= pout_d;
      last_q <= last_d;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.event_code   = ev_q;
  assign res.payload_out  = pout_q;
  assign res.last_payload = last_q;

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_PAYLOAD && cnt_inc >= eff_len |=>
      res.last_payload && res.event_code == EV_DATA && phase_q == PH_CRC_HI)
    else $error("last payload byte did not end the payload phase");

  a_crc_lo_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_CRC_LO |=> phase_q == PH_HUNT && payload_cnt_q == '0)
    else $error("frame did not return to hunting after crc check");

  a_sync_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_HUNT |-> sync_cnt_q == '0)
    else $error("sync count not cleared outside hunt");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_cnt_q <= LenWidth'(MaxPayload))
    else $error("payload count beyond maximum");

endmodule

`default_nettype wire

### verif/swfc_frame_checker.sv
// frame event predictor and result comparison for the sync word frame crc checker
`timescale 1ns / 1ps

module swfc_frame_checker
  import swfc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  swfc_in_if                          rx,
  swfc_out_if                         res,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [SyncWidth-1:0]   cfg_wdata_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);

  typedef struct packed {
    event_e               code;
    logic [ByteWidth-1:0] data;
    logic                 last_flag;
  } frame_event_t;

  frame_event_t events_due[$];
  int unsigned  mismatch_count;

  logic [SyncWidth-1:0] sync_word;
  logic [LenWidth-1:0]  frame_len;
  frame_phase_e         phase;
  logic [2:0]           sync_hits;
  logic [LenWidth-1:0]  bytes_taken;
  logic [CrcWidth-1:0]  crc_acc;
  logic [ByteWidth-1:0] crc_hi_rx;

  assign fail_count_o = mismatch_count;

  function automatic logic [CrcWidth-1:0] crc16_ccitt_byte(input logic [CrcWidth-1:0] crc,
                                                          input logic [ByteWidth-1:0] d);
    logic [CrcWidth-1:0] r;
    logic                fb;
    r = crc;
    for (int i = ByteWidth - 1; i >= 0; i--) begin
      fb = r[CrcWidth-1] ^ d[i];
      r  = {r[CrcWidth-2:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // zero acts as one byte, anything above the maximum is clamped
  function automatic logic [LenWidth-1:0] active_len();
    if (frame_len == '0) begin
      return LenWidth'(1);
    end
    if (frame_len > MaxPayload) begin
      return LenWidth'(MaxPayload);
    end
    return frame_len;
  endfunction

  function automatic frame_event_t predict_frame_event(input logic [ByteWidth-1:0] rx_b);
    frame_event_t         ev;
    logic [ByteWidth-1:0] want_b;
    ev.code      = EV_HUNT;
    ev.data      = '0;
    ev.last_flag = 1'b0;
    case (phase)
      PH_HUNT: begin
        want_b = sync_word[8 * (3 - sync_hits[1:0]) +: 8];
        if (rx_b == want_b) begin
          ev.code = EV_SYNC;
          if (sync_hits[1:0] == 2'd3) begin
            sync_hits   = '0;
            bytes_taken = '0;
            crc_acc     = CrcInit;
            phase       = PH_PAYLOAD;
          end else begin
            sync_hits = sync_hits + 3'd1;
          end
        end else begin
          sync_hits = '0;
        end
      end
      PH_PAYLOAD: begin
        ev.code = EV_DATA;
        ev.data = rx_b;
        crc_acc = crc16_ccitt_byte(crc_acc, rx_b);
        if (bytes_taken < MaxPayload) begin
          bytes_taken = bytes_taken + 1'b1;
        end
        if (bytes_taken >= active_len()) begin
          ev.last_flag = 1'b1;
          phase        = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        ev.code   = EV_CRC_HI;
        crc_hi_rx = rx_b;
        phase     = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi_rx, rx_b} == crc_acc) begin
          ev.code = EV_GOOD;
        end else begin
          ev.code = EV_BAD;
        end
        phase       = PH_HUNT;
        sync_hits   = '0;
        bytes_taken = '0;
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_event_t want;
    if (!rst_ni) begin
      sync_word      = SyncReset;
      frame_len      = PayloadLenRst;
      phase          = PH_HUNT;
      sync_hits      = '0;
      bytes_taken    = '0;
      crc_acc        = CrcInit;
      crc_hi_rx      = '0;
      mismatch_count = 0;
      events_due.delete();
      pending_o <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (events_due.size() == 0) begin
          $error("result without a pending request: event_code %0d", res.event_code);
          mismatch_count++;
        end else begin
          want = events_due.pop_front();
          if (res.event_code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, res.event_code);
            mismatch_count++;
          end
          if (res.payload_out !== want.data) begin
            $error("payload_out: expected %0d, got %0d", want.data, res.payload_out);
            mismatch_count++;
          end
          if (res.last_payload !== want.last_flag) begin
            $error("last_payload: expected %0d, got %0d", want.last_flag, res.last_payload);
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SYNC_PATTERN:   sync_word = cfg_wdata_i;
          REG_PAYLOAD_LENGTH: frame_len = cfg_wdata_i[LenWidth-1:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) begin
        events_due.push_back(predict_frame_event(rx.rx_byte));
      end
      pending_o <= events_due.size();
    end
  end

endmodule

### verif/tb_sync_word_frame_crc_checker_core.sv
// testbench top: byte stream stimulus, handshake pressure and verdict for the frame crc checker
`timescale 1ns / 1ps

module tb_sync_word_frame_crc_checker_core;
  import swfc_pkg::*;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned IdlePct       = 33;
  localparam int unsigned PhaseItems    = 58;
  localparam int unsigned RandomPhases  = 8;
  localparam logic [CfgIdxWidth-1:0] RegBeyondList = 2'd2;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [SyncWidth-1:0]   cfg_wdata_i;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_seq;

  logic [SyncWidth-1:0] cur_sync;
  logic [LenWidth-1:0]  cur_len;

  swfc_in_if  rx_if ();
  swfc_out_if res_if ();

  sync_word_frame_crc_checker_core i_dut (
    .clk_i,
    .rst_ni,
    .rx          (rx_if),
    .res         (res_if),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  swfc_frame_checker i_checker (
    .clk_i,
    .rst_ni,
    .rx           (rx_if),
    .res          (res_if),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .pending_o    (pending),
    .fail_count_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result receiver with random stalls and requested long hold-offs
  initial begin : receiver
    int unsigned seen;
    seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        res_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic int unsigned frame_bytes();
    if (cur_len == '0) begin
      return 1;
    end
    if (cur_len > MaxPayload) begin
      return MaxPayload;
    end
    return 32'(cur_len);
  endfunction

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [SyncWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_SYNC_PATTERN) begin
      cur_sync = val;
    end else if (idx == REG_PAYLOAD_LENGTH) begin
      cur_len = val[LenWidth-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [ByteWidth-1:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    items_sent++;
  endtask

  task automatic send_sync();
    for (int i = 0; i < 4; i++) begin
      send_byte(cur_sync[31 - 8 * i -: 8]);
    end
  endtask

  task automatic send_data(inout logic [CrcWidth-1:0] crc);
    logic [ByteWidth-1:0] b;
    b   = ByteWidth'($urandom);
    crc = crc_fold(crc, b);
    send_byte(b);
  endtask

  task automatic send_crc(input logic [CrcWidth-1:0] crc, input bit corrupt);
    if (corrupt) begin
      crc = crc ^ CrcWidth'($urandom_range(16'hFFFF, 1));
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  task automatic send_frame(input int unsigned len, input bit corrupt);
    logic [CrcWidth-1:0] crc;
    crc = CrcInit;
    send_sync();
    repeat (len) send_data(crc);
    send_crc(crc, corrupt);
  endtask

  // payload length rewritten after head bytes of a frame
  task automatic send_cut_frame(input int unsigned head, input logic [LenWidth-1:0] new_len,
                                input bit corrupt);
    logic [CrcWidth-1:0] crc;
    int unsigned         tail;
    crc = CrcInit;
    send_sync();
    repeat (head) send_data(crc);
    drain();
    write_reg(REG_PAYLOAD_LENGTH, SyncWidth'(new_len));
    tail = (frame_bytes() > head) ? frame_bytes() - head : 1;
    repeat (tail) send_data(crc);
    send_crc(crc, corrupt);
  endtask

  initial begin : stimulus
    logic [SyncWidth-1:0] sync_val;
    int unsigned          len;
    int unsigned          phase_end;
    int unsigned          pick;
    int unsigned          k;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_SYNC_PATTERN;
    cfg_wdata_i   <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    sink_idle_pct <= IdlePct;
    hold_seq      <= 0;
    src_idle_pct  = IdlePct;
    cur_sync      = SyncReset;
    cur_len       = PayloadLenRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray bytes, then a repeated first sync byte that loses the word
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync[31:24]);
    send_sync();
    send_cut_frame(3, LenWidth'(2), 1'b0);
    drain();
    write_reg(RegBeyondList, $urandom);
    write_reg(REG_PAYLOAD_LENGTH, '0);
    send_frame(frame_bytes(), 1'b1);

    // oversized and largest lengths, each frame cut short by a rewrite
    drain();
    write_reg(REG_PAYLOAD_LENGTH, SyncWidth'(13'h1FFF));
    send_cut_frame(6, LenWidth'(9), 1'b0);
    drain();
    write_reg(REG_PAYLOAD_LENGTH, MaxPayload);
    send_cut_frame(5, LenWidth'(3), 1'($urandom_range(1)));

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case (p)
        0:       sync_val = '0;
        1:       sync_val = '1;
        default: sync_val = $urandom;
      endcase
      write_reg(REG_SYNC_PATTERN, sync_val);
      if ($urandom_range(1)) begin
        write_reg(RegBeyondList, $urandom);
      end
      if (p == 2) begin
        len = 0;
      end else if (p == 6) begin
        len = $urandom_range(40, 13);
      end else begin
        len = $urandom_range(12, 1);
      end
      write_reg(REG_PAYLOAD_LENGTH, len);
      if (p == 3) begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      if (p == 5) begin
        src_idle_pct = 0;
        hold_seq <= hold_seq + 1;
      end
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame(frame_bytes(), 1'b0);
        end else if (pick < 82) begin
          send_frame(frame_bytes(), 1'b1);
        end else if (pick < 90) begin
          repeat ($urandom_range(4, 1)) send_byte(ByteWidth'($urandom));
        end else begin
          // partial sync word broken by a wrong byte
          k = $urandom_range(3, 1);
          for (int i = 0; i < k; i++) begin
            send_byte(cur_sync[31 - 8 * i -: 8]);
          end
          send_byte(~cur_sync[31 - 8 * k -: 8]);
        end
      end
      src_idle_pct = IdlePct;
      sink_idle_pct <= IdlePct;
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/swfc_pkg.sv
rtl/swfc_in_if.sv
rtl/swfc_out_if.sv
rtl/sync_word_frame_crc_checker_core.sv
verif/swfc_frame_checker.sv
verif/tb_sync_word_frame_crc_checker_core.sv
